FILE: design/cplx_pkg.sv
`default_nettype none
package cplx_pkg;
   localparam int FRAC_BITS = 8;
   localparam int WORD_BITS = 16;
   localparam int PROD_BITS = 2 * WORD_BITS;
   localparam int NUM_BITS  = PROD_BITS + 1;
   localparam int MAG_BITS  = PROD_BITS;
   // quotient bits kept before clipping; integer part plus fraction
   localparam int QUO_BITS  = WORD_BITS + FRAC_BITS + 1;
   // restoring steps: integer part (bounded) then fraction bits
   localparam int INT_STEPS = WORD_BITS + 1;
   localparam int DIV_STEPS = INT_STEPS + FRAC_BITS;
   localparam int DIV_PER_STAGE = 2;
   localparam int DIV_STAGES = (DIV_STEPS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;

   typedef enum logic [1:0] {
      CMD_ADD = 2'd0,
      CMD_SUB = 2'd1,
      CMD_MUL = 2'd2,
      CMD_DIV = 2'd3
   } cmd_type;

   typedef logic signed [WORD_BITS-1:0] word_type;

   // one divider lane in flight
   typedef struct packed {
      logic                     neg;
      logic [MAG_BITS+QUO_BITS-1:0] rem;  // shifted dividend / partial remainder
      logic [QUO_BITS-1:0]      quo;
   } lane_type;

   typedef struct packed {
      cmd_type                  cmd;
      logic                     dz;
      logic signed [NUM_BITS-1:0] num_re;
      logic signed [NUM_BITS-1:0] num_im;
      logic [MAG_BITS-1:0]      den;
   } front_type;
endpackage
`default_nettype wire

FILE: design/cplx_front.sv
`default_nettype none
// Operand stages: products and sums registered, then numerators registered.
module cplx_front (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic adv,
   input  wire logic in_valid,
   input  cplx_pkg::cmd_type cmd,
   input  cplx_pkg::word_type a_re,
   input  cplx_pkg::word_type a_im,
   input  cplx_pkg::word_type b_re,
   input  cplx_pkg::word_type b_im,
   output logic out_valid,
   output cplx_pkg::front_type out_data
);
   import cplx_pkg::*;

   logic v1_ff;
   cmd_type cmd1_ff;
   logic signed [PROD_BITS-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, p_bb_ff, p_cc_ff;
   logic signed [WORD_BITS:0] s_re_ff, s_im_ff;
   logic v2_ff;
   front_type d2_ff, d2_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cmd1_ff <= cmd;
         p_rr_ff <= a_re * b_re;
         p_ii_ff <= a_im * b_im;
         p_ri_ff <= a_re * b_im;
         p_ir_ff <= a_im * b_re;
         p_bb_ff <= b_re * b_re;
         p_cc_ff <= b_im * b_im;
         if (cmd == CMD_SUB) begin
            s_re_ff <= {a_re[WORD_BITS-1], a_re} - {b_re[WORD_BITS-1], b_re};
            s_im_ff <= {a_im[WORD_BITS-1], a_im} - {b_im[WORD_BITS-1], b_im};
         end else begin
            s_re_ff <= {a_re[WORD_BITS-1], a_re} + {b_re[WORD_BITS-1], b_re};
            s_im_ff <= {a_im[WORD_BITS-1], a_im} + {b_im[WORD_BITS-1], b_im};
         end
         d2_ff <= d2_in;
      end
   end

   logic signed [NUM_BITS-1:0] e_rr, e_ii, e_ri, e_ir;
   logic [MAG_BITS:0] den_w;
   always_comb begin
      e_rr = NUM_BITS'(p_rr_ff);
      e_ii = NUM_BITS'(p_ii_ff);
      e_ri = NUM_BITS'(p_ri_ff);
      e_ir = NUM_BITS'(p_ir_ff);
      den_w = {1'b0, p_bb_ff} + {1'b0, p_cc_ff};
      d2_in.cmd = cmd1_ff;
      d2_in.den = den_w[MAG_BITS-1:0];
      d2_in.dz = (cmd1_ff == CMD_DIV) && (den_w == '0);
      case (cmd1_ff)
         CMD_ADD, CMD_SUB: begin
            d2_in.num_re = NUM_BITS'(s_re_ff);
            d2_in.num_im = NUM_BITS'(s_im_ff);
         end
         CMD_MUL: begin
            d2_in.num_re = e_rr - e_ii;
            d2_in.num_im = e_ri + e_ir;
         end
         default: begin
            d2_in.num_re = e_rr + e_ii;
            d2_in.num_im = e_ir - e_ri;
         end
      endcase
   end

   assign out_valid = v2_ff;
   assign out_data  = d2_ff;
endmodule
`default_nettype wire

FILE: design/cplx_div.sv
`default_nettype none
// Pipelined restoring divider, DIV_PER_STAGE quotient bits per stage, two lanes.
// Non-divide items ride along; finisher picks the right result.
module cplx_div (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic adv,
   input  wire logic in_valid,
   input  cplx_pkg::front_type in_data,
   output logic out_valid,
   output cplx_pkg::front_type out_data,
   output cplx_pkg::lane_type out_re,
   output cplx_pkg::lane_type out_im,
   output logic out_ovf_re,
   output logic out_ovf_im
);
   import cplx_pkg::*;

   localparam int RW = MAG_BITS + QUO_BITS;

   logic        v_ff   [DIV_STAGES+1];
   front_type   d_ff   [DIV_STAGES+1];
   lane_type    re_ff  [DIV_STAGES+1];
   lane_type    im_ff  [DIV_STAGES+1];
   lane_type    re_in  [DIV_STAGES+1];
   lane_type    im_in  [DIV_STAGES+1];

   function automatic lane_type lane_init(input logic signed [NUM_BITS-1:0] n);
      lane_type l;
      logic [NUM_BITS-1:0] m;
      l.neg = n[NUM_BITS-1];
      m = l.neg ? NUM_BITS'(-n) : NUM_BITS'(n);
      l.rem = RW'(m[MAG_BITS-1:0]);
      l.quo = '0;
      return l;
   endfunction

   // step k: compare with den shifted to bit position of quotient weight
   function automatic lane_type lane_step(input lane_type l, input logic [MAG_BITS-1:0] den,
                                          input int k);
      lane_type r;
      logic [RW+QUO_BITS-1:0] sd;
      int sh;
      r = l;
      sh = INT_STEPS - 1 - k;
      if (k < DIV_STEPS) begin
         // fraction steps (sh < 0): scale remainder by shifting it left instead of den
         if (sh >= 0) sd = (RW+QUO_BITS)'(den) << sh;
         else sd = (RW+QUO_BITS)'(den);
         if (sh < 0) r.rem = {r.rem[RW-2:0], 1'b0};
         r.quo = {r.quo[QUO_BITS-2:0], 1'b0};
         if ((RW+QUO_BITS)'(r.rem) >= sd) begin
            r.rem = RW'((RW+QUO_BITS)'(r.rem) - sd);
            r.quo[0] = 1'b1;
         end
      end
      return r;
   endfunction

   always_comb begin
      re_in[0] = lane_init(in_data.num_re);
      im_in[0] = lane_init(in_data.num_im);
      for (int s = 1; s <= DIV_STAGES; s++) begin
         lane_type tr, ti;
         tr = re_ff[s-1];
         ti = im_ff[s-1];
         for (int j = 0; j < DIV_PER_STAGE; j++) begin
            tr = lane_step(tr, d_ff[s-1].den, (s-1)*DIV_PER_STAGE + j);
            ti = lane_step(ti, d_ff[s-1].den, (s-1)*DIV_PER_STAGE + j);
         end
         re_in[s] = tr;
         im_in[s] = ti;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= DIV_STAGES; s++) v_ff[s] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= in_valid;
         for (int s = 1; s <= DIV_STAGES; s++) v_ff[s] <= v_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_ff[0]  <= in_data;
         re_ff[0] <= re_in[0];
         im_ff[0] <= im_in[0];
         for (int s = 1; s <= DIV_STAGES; s++) begin
            d_ff[s]  <= d_ff[s-1];
            re_ff[s] <= re_in[s];
            im_ff[s] <= im_in[s];
         end
      end
   end

   // integer quotient can reach 2^(MAG_BITS) in theory; check leftover above the
   // span covered by the integer steps: mag >= den << INT_STEPS means overflow
   logic ovr_re_in, ovr_im_in;
   always_comb begin
      ovr_re_in = (RW'(re_ff[0].rem) >> INT_STEPS) >= RW'(d_ff[0].den);
      ovr_im_in = (RW'(im_ff[0].rem) >> INT_STEPS) >= RW'(d_ff[0].den);
   end
   logic ovr_re_q [DIV_STAGES];
   logic ovr_im_q [DIV_STAGES];
   always_ff @(posedge clock) begin
      if (adv) begin
         ovr_re_q[0] <= ovr_re_in;
         ovr_im_q[0] <= ovr_im_in;
         for (int s = 1; s < DIV_STAGES; s++) begin
            ovr_re_q[s] <= ovr_re_q[s-1];
            ovr_im_q[s] <= ovr_im_q[s-1];
         end
      end
   end
   assign out_ovf_re = ovr_re_q[DIV_STAGES-1];
   assign out_ovf_im = ovr_im_q[DIV_STAGES-1];

   assign out_valid = v_ff[DIV_STAGES];
   assign out_data  = d_ff[DIV_STAGES];
   assign out_re    = re_ff[DIV_STAGES];
   assign out_im    = im_ff[DIV_STAGES];
endmodule
`default_nettype wire

FILE: design/complex_arith_alu.sv
// Complex ALU: add, subtract, multiply, divide on signed Q7.8 complex operands.
// Fully pipelined: one request accepted per cycle while the pipeline is not
// stalled, and every operation passes through the pipelined restoring divider.
// Back pressure on rsp_ready stalls the whole pipeline; nothing is lost. Multiply
// floors, divide truncates toward zero, results saturate with a flag; divide
// by zero gives zero with div_by_zero set.
`default_nettype none
module complex_arith_alu (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_ready,
   input  wire logic [1:0] req_cmd,
   input  wire logic signed [cplx_pkg::WORD_BITS-1:0] req_a_re,
   input  wire logic signed [cplx_pkg::WORD_BITS-1:0] req_a_im,
   input  wire logic signed [cplx_pkg::WORD_BITS-1:0] req_b_re,
   input  wire logic signed [cplx_pkg::WORD_BITS-1:0] req_b_im,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output logic signed [cplx_pkg::WORD_BITS-1:0] rsp_res_re,
   output logic signed [cplx_pkg::WORD_BITS-1:0] rsp_res_im,
   output logic      rsp_saturated,
   output logic      rsp_div_by_zero
);
   import cplx_pkg::*;

   localparam logic signed [QUO_BITS+1:0] POS_MAX = (QUO_BITS+2)'((1 <<< (WORD_BITS-1)) - 1);
   localparam logic signed [QUO_BITS+1:0] NEG_MIN = -(QUO_BITS+2)'(1 <<< (WORD_BITS-1));

   logic adv;
   logic f_valid, d_valid;
   front_type f_data, d_data;
   lane_type d_re, d_im;
   logic ovf_re, ovf_im;

   // output register; whole pipe moves when it is empty or being drained
   logic o_valid_ff;
   assign adv = !o_valid_ff || rsp_ready;
   assign req_ready = adv;

   cplx_front u_front (
      .clock, .reset, .adv,
      .in_valid (req_valid),
      .cmd      (cmd_type'(req_cmd)),
      .a_re     (req_a_re), .a_im(req_a_im), .b_re(req_b_re), .b_im(req_b_im),
      .out_valid(f_valid),
      .out_data (f_data)
   );

   cplx_div u_div (
      .clock, .reset, .adv,
      .in_valid  (f_valid),
      .in_data   (f_data),
      .out_valid (d_valid),
      .out_data  (d_data),
      .out_re    (d_re),
      .out_im    (d_im),
      .out_ovf_re(ovf_re),
      .out_ovf_im(ovf_im)
   );

   // clip a wide signed value; flag on clip
   function automatic logic [WORD_BITS:0] clip(input logic signed [NUM_BITS:0] v);
      logic [WORD_BITS:0] r;
      if (v > NUM_BITS'(POS_MAX) && v > (NUM_BITS+1)'(POS_MAX))
         r = {1'b1, WORD_BITS'(POS_MAX)};
      else if (v < (NUM_BITS+1)'(NEG_MIN))
         r = {1'b1, WORD_BITS'(NEG_MIN)};
      else
         r = {1'b0, WORD_BITS'(v)};
      return r;
   endfunction

   function automatic logic [WORD_BITS:0] div_fin(input lane_type l, input logic ovf);
      logic signed [NUM_BITS:0] v;
      if (ovf)
         v = l.neg ? -(NUM_BITS+1)'(1 <<< WORD_BITS) : (NUM_BITS+1)'(1 <<< WORD_BITS);
      else
         v = l.neg ? -(NUM_BITS+1)'(l.quo) : (NUM_BITS+1)'(l.quo);
      return clip(v);
   endfunction

   logic [WORD_BITS:0] r_re, r_im;
   always_comb begin
      case (d_data.cmd)
         CMD_ADD, CMD_SUB: begin
            r_re = clip((NUM_BITS+1)'(d_data.num_re));
            r_im = clip((NUM_BITS+1)'(d_data.num_im));
         end
         CMD_MUL: begin
            r_re = clip((NUM_BITS+1)'(d_data.num_re >>> FRAC_BITS));
            r_im = clip((NUM_BITS+1)'(d_data.num_im >>> FRAC_BITS));
         end
         default: begin
            if (d_data.dz) begin
               r_re = '0;
               r_im = '0;
            end else begin
               r_re = div_fin(d_re, ovf_re);
               r_im = div_fin(d_im, ovf_im);
            end
         end
      endcase
   end

   logic signed [WORD_BITS-1:0] re_ff, im_ff;
   logic sat_ff, dz_ff;
   always_ff @(posedge clock) begin
      if (reset) o_valid_ff <= 1'b0;
      else if (adv) o_valid_ff <= d_valid;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         re_ff  <= r_re[WORD_BITS-1:0];
         im_ff  <= r_im[WORD_BITS-1:0];
         sat_ff <= r_re[WORD_BITS] | r_im[WORD_BITS];
         dz_ff  <= d_data.dz;
      end
   end

   assign rsp_valid       = o_valid_ff;
   assign rsp_res_re      = re_ff;
   assign rsp_res_im      = im_ff;
   assign rsp_saturated   = sat_ff;
   assign rsp_div_by_zero = dz_ff;

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_div_by_zero |-> rsp_res_re == '0 && rsp_res_im == '0 && !rsp_saturated)
      else $error("div by zero result not zero");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_res_re) && $stable(rsp_res_im))
      else $error("result changed under stall");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("pipe stalled while output empty");
endmodule
`default_nettype wire
